FILE: rtl/core/base64_line_wrapped_encoder_core_defines.svh
// Assertion macros for the line wrapped base64 encoder core
`ifndef BASE64_LINE_WRAPPED_ENCODER_CORE_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_CORE_DEFINES_SVH

`ifndef SYNTH
`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define B64E_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define B64E_ASSERT(label, prop, msg)
`define B64E_ASSERT_IMPL(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/b64e_pkg.sv
// Shared types, constants and the base64 alphabet for the encoder core
package b64e_pkg;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'd61;

  localparam logic [5:0] GROUPS_PER_LINE_RESET = 6'd19;

  localparam int unsigned MAX_CHARS   = 6;
  localparam int unsigned COUNT_W     = $clog2(MAX_CHARS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_CHARS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [COUNT_W-1:0]        count;
    logic                      last;
  } entry_t;

  function automatic logic [7:0] b64e_alpha(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      return 8'(8'd65 + w);
    end else if (v < 6'd52) begin
      return 8'(8'd71 + w);
    end else if (v < 6'd62) begin
      return 8'(w - 8'd4);
    end else if (v == 6'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

endpackage

FILE: rtl/core/base64_line_wrapped_encoder_core.sv
// Top level of the line wrapped base64 encoder core
// Input channel: in_valid_i with data_byte_i and last_byte_i; a transfer
// happens when in_valid_i is high and in_stall_o is low. Output channel:
// out_valid_o with out_char_o and last_char_o, transferred when
// out_stall_i is low. last_char_o marks the closing LF of a message.
// groups_per_line is written through cfg_we_i / cfg_wdata_i; the user must
// do so only while idle, as the block itself does not enforce it. Each byte
// yields one to six characters (base64 code, '=', CR, LF). The front end
// turns a byte into a character entry in the cycle of its transfer; a
// two-entry queue feeds the serializer, which sends one character per cycle
// while out_stall_i is low. The first character passes through the queue
// and the serializer's entry register before it is valid. Input is taken
// every cycle while the queue has room, so the sustained input rate is set
// by the serializer, which also sends the CR LF that ends each line.
// Reset clears the group, line and queue state and sets 19 groups per line.
// When out_stall_i holds, the current character holds, the queue fills and
// in_stall_o rises.
module base64_line_wrapped_encoder_core
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

`include "base64_line_wrapped_encoder_core_defines.svh"

  entry_t front_entry;
  entry_t q_head;
  logic   push;
  logic   pop;
  logic   q_valid;
  logic   q_full;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .entry_o     (front_entry)
  );

  b64e_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (front_entry),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .full_o       (q_full),
    .head_o       (q_head)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

  `B64E_ASSERT_IMPL(a_last_is_lf, out_valid_o && last_char_o, out_char_o == CHAR_LF, "last not LF")
  `B64E_ASSERT_IMPL(a_full_has_data, q_full, q_valid, "queue full but empty")
  `B64E_ASSERT(a_pop_needs_data, !pop || q_valid, "pop from empty queue")
  `B64E_ASSERT_IMPL(a_pop_after_push, !q_valid && !push, ##1 !pop, "pop without entry")

endmodule

FILE: rtl/core/b64e_front.sv
// Front end: accept bytes, track group and line state, build character entries
module b64e_front
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output entry_t     entry_o
);

  logic [5:0] groups_per_line_q;
  logic [1:0] group_pos_q, group_pos_d;
  logic [3:0] leftover_q, leftover_d;
  logic [5:0] line_groups_q, line_groups_d;
  logic [5:0] limit;
  logic [5:0] lg_inc;
  logic       line_full;

  assign limit     = (groups_per_line_q == 6'd0) ? 6'd1 : groups_per_line_q;
  assign lg_inc    = line_groups_q + 6'd1;
  assign line_full = lg_inc >= limit;

  always_comb begin
    entry_o       = '0;
    entry_o.last  = last_byte_i;
    group_pos_d   = group_pos_q;
    leftover_d    = leftover_q;
    line_groups_d = line_groups_q;
    unique case (group_pos_q)
      2'd1: begin
        entry_o.chars[0] = b64e_alpha({leftover_q[1:0], data_byte_i[7:4]});
        if (last_byte_i) begin
          entry_o.chars[1] = b64e_alpha({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = CHAR_PAD;
          entry_o.chars[3] = CHAR_CR;
          entry_o.chars[4] = CHAR_LF;
          entry_o.count    = COUNT_W'(5);
        end else begin
          entry_o.count    = COUNT_W'(1);
        end
        group_pos_d = 2'd2;
        leftover_d  = data_byte_i[3:0];
      end
      2'd2: begin
        entry_o.chars[0] = b64e_alpha({leftover_q, data_byte_i[7:6]});
        entry_o.chars[1] = b64e_alpha(data_byte_i[5:0]);
        if (line_full || last_byte_i) begin
          entry_o.chars[2] = CHAR_CR;
          entry_o.chars[3] = CHAR_LF;
          entry_o.count    = COUNT_W'(4);
        end else begin
          entry_o.count    = COUNT_W'(2);
        end
        group_pos_d   = 2'd0;
        leftover_d    = 4'd0;
        line_groups_d = line_full ? 6'd0 : lg_inc;
      end
      default: begin
        entry_o.chars[0] = b64e_alpha(data_byte_i[7:2]);
        if (last_byte_i) begin
          entry_o.chars[1] = b64e_alpha({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = CHAR_PAD;
          entry_o.chars[3] = CHAR_PAD;
          entry_o.chars[4] = CHAR_CR;
          entry_o.chars[5] = CHAR_LF;
          entry_o.count    = COUNT_W'(6);
        end else begin
          entry_o.count    = COUNT_W'(1);
        end
        group_pos_d = 2'd1;
        leftover_d  = {2'b00, data_byte_i[1:0]};
      end
    endcase
    if (last_byte_i) begin
      group_pos_d   = 2'd0;
      leftover_d    = 4'd0;
      line_groups_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_per_line_q <= GROUPS_PER_LINE_RESET;
      group_pos_q       <= 2'd0;
      leftover_q        <= 4'd0;
      line_groups_q     <= 6'd0;
    end else begin
      if (cfg_we_i) begin
        groups_per_line_q <= cfg_wdata_i;
      end
      if (push_i) begin
        group_pos_q   <= group_pos_d;
        leftover_q    <= leftover_d;
        line_groups_q <= line_groups_d;
      end
    end
  end

endmodule

FILE: rtl/core/b64e_queue.sv
// Short entry queue between the front end and the character serializer
module b64e_queue
  import b64e_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output logic   valid_o,
  output logic   full_o,
  output entry_t head_o
);

  entry_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q;
  logic [QPTR_W-1:0]   rd_ptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign head_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/b64e_back.sv
// Back end: serialize one queued entry as one character per transfer
module b64e_back
  import b64e_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic             busy_q;
  entry_t           entry_q;
  logic [IDX_W-1:0] idx_q;
  logic             xfer;
  logic             at_end;

  assign xfer        = busy_q && !out_stall_i;
  assign at_end      = COUNT_W'(idx_q) == entry_q.count - COUNT_W'(1);
  assign pop_o       = q_valid_i && (!busy_q || (xfer && at_end));
  assign out_valid_o = busy_q;
  assign out_char_o  = entry_q.chars[idx_q];
  assign last_char_o = entry_q.last && at_end;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      priority if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (xfer && at_end) begin
        busy_q <= 1'b0;
      end else if (xfer) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule
